>>> src/ujcc_pkg.sv
// shared types and code-point constants for the japanese utf-8 character classifier
package ujcc_pkg;

  // dense class codes of one character
  typedef enum logic [3:0] {
    CLASS_OTHER     = 4'd0,
    CLASS_ASCII     = 4'd1,
    CLASS_KANJI3    = 4'd2,
    CLASS_KANJI4    = 4'd3,
    CLASS_KATAKANA  = 4'd4,
    CLASS_HIRAGANA  = 4'd5,
    CLASS_FULLWIDTH = 4'd6,
    CLASS_COMMA     = 4'd7,
    CLASS_STOP      = 4'd8,
    CLASS_OPEN      = 4'd9,
    CLASS_CLOSE     = 4'd10,
    CLASS_DOT       = 4'd11,
    CLASS_ITERATION = 4'd12,
    CLASS_DASH      = 4'd13
  } char_class_t;

  // field widths
  localparam int unsigned WordW  = 32;
  localparam int unsigned LenW   = 3;
  localparam int unsigned AsciiW = 7;
  localparam int unsigned ClassW = 4;

  // byte length codes
  localparam logic [LenW-1:0] LEN_ONE   = 3'd1;
  localparam logic [LenW-1:0] LEN_TWO   = 3'd2;
  localparam logic [LenW-1:0] LEN_THREE = 3'd3;
  localparam logic [LenW-1:0] LEN_FOUR  = 3'd4;

  // lead byte thresholds
  localparam logic [7:0] LEAD_TWO   = 8'h80;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR  = 8'hF0;

  // exclusive range bounds on the first three bytes
  localparam logic [23:0] K3A_LO  = 24'hE38FBF;
  localparam logic [23:0] K3A_HI  = 24'hE9BFAF;
  localparam logic [23:0] K3B_LO  = 24'hEFA3BF;
  localparam logic [23:0] K3B_HI  = 24'hEFAC80;
  localparam logic [23:0] KATA_LO = 24'hE382A0;
  localparam logic [23:0] KATA_HI = 24'hE383BA;
  localparam logic [23:0] HIRA_LO = 24'hE38180;
  localparam logic [23:0] HIRA_HI = 24'hE382A0;
  localparam logic [23:0] FW_LO   = 24'hEFBC80;
  localparam logic [23:0] FW_HI   = 24'hEFBD9F;

  // exclusive range bounds on all four bytes
  localparam logic [31:0] K4_LO = 32'hF09FAFBF;
  localparam logic [31:0] K4_HI = 32'hF0B18D8B;

  // single code points
  localparam logic [23:0] CP_IDEO_SPACE = 24'hE38080;
  localparam logic [23:0] CP_COMMA      = 24'hE38081;
  localparam logic [23:0] CP_STOP       = 24'hE38082;
  localparam logic [23:0] CP_OPEN_A     = 24'hE3808C;
  localparam logic [23:0] CP_OPEN_B     = 24'hE3808E;
  localparam logic [23:0] CP_CLOSE_A    = 24'hE3808D;
  localparam logic [23:0] CP_CLOSE_B    = 24'hE3808F;
  localparam logic [23:0] CP_DOT        = 24'hE383BB;
  localparam logic [23:0] CP_ITERATION  = 24'hE380BB;

  // dash code points
  localparam int unsigned DashN = 8;
  localparam logic [23:0] DASH_POINTS [DashN] = '{
    24'hE383BC, 24'hE28095, 24'hE28094, 24'hE28093,
    24'hE28092, 24'hE28091, 24'hE28090, 24'hE28892
  };

  // fullwidth form bytes and offsets
  localparam logic [7:0] FW_LEAD     = 8'hEF;
  localparam logic [7:0] FW_ROW_A    = 8'hBC;
  localparam logic [7:0] FW_ROW_B    = 8'hBD;
  localparam logic [7:0] FW_CONT_MIN = 8'h80;
  localparam logic [7:0] FW_A_END    = 8'hC0;
  localparam logic [7:0] FW_B_END    = 8'h9F;
  localparam logic [7:0] FW_A_OFS    = 8'h60;
  localparam logic [7:0] FW_B_OFS    = 8'h20;
  localparam logic [7:0] K3_LEAD_GT  = 8'hE2;

endpackage

>>> src/ujcc_classify.sv
// combinational length, class and ascii decode of one utf-8 character
module ujcc_classify (
  input  logic [ujcc_pkg::WordW-1:0]  word,
  output ujcc_pkg::char_class_t       char_class,
  output logic [ujcc_pkg::LenW-1:0]   byte_length,
  output logic [ujcc_pkg::AsciiW-1:0] ascii_equivalent
);

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [23:0] k3;
  logic        is_dash;
  logic [7:0]  fw_a;
  logic [7:0]  fw_b;

  assign b0 = word[31:24];
  assign b1 = word[23:16];
  assign b2 = word[15:8];
  assign k3 = word[31:8];

  // length from lead byte
  always_comb begin
    priority if (b0 < ujcc_pkg::LEAD_TWO) begin
      byte_length = ujcc_pkg::LEN_ONE;
    end else if (b0 < ujcc_pkg::LEAD_THREE) begin
      byte_length = ujcc_pkg::LEN_TWO;
    end else if (b0 < ujcc_pkg::LEAD_FOUR) begin
      byte_length = ujcc_pkg::LEN_THREE;
    end else begin
      byte_length = ujcc_pkg::LEN_FOUR;
    end
  end

  // match against the dash list
  always_comb begin
    is_dash = 1'b0;
    for (int i = 0; i < ujcc_pkg::DashN; i++) begin
      if (k3 == ujcc_pkg::DASH_POINTS[i]) is_dash = 1'b1;
    end
  end

  // class, first match wins
  always_comb begin
    priority if (byte_length == ujcc_pkg::LEN_ONE) begin
      char_class = ujcc_pkg::CLASS_ASCII;
    end else if (byte_length == ujcc_pkg::LEN_TWO) begin
      char_class = ujcc_pkg::CLASS_OTHER;
    end else if (k3 == ujcc_pkg::CP_IDEO_SPACE) begin
      char_class = ujcc_pkg::CLASS_OTHER;
    end else if ((b0 > ujcc_pkg::K3_LEAD_GT) &&
                 (((k3 > ujcc_pkg::K3A_LO) && (k3 < ujcc_pkg::K3A_HI)) ||
                  ((k3 > ujcc_pkg::K3B_LO) && (k3 < ujcc_pkg::K3B_HI)))) begin
      char_class = ujcc_pkg::CLASS_KANJI3;
    end else if ((b0 == ujcc_pkg::LEAD_FOUR) &&
                 (word > ujcc_pkg::K4_LO) && (word < ujcc_pkg::K4_HI)) begin
      char_class = ujcc_pkg::CLASS_KANJI4;
    end else if ((k3 > ujcc_pkg::KATA_LO) && (k3 < ujcc_pkg::KATA_HI)) begin
      char_class = ujcc_pkg::CLASS_KATAKANA;
    end else if ((k3 > ujcc_pkg::HIRA_LO) && (k3 < ujcc_pkg::HIRA_HI)) begin
      char_class = ujcc_pkg::CLASS_HIRAGANA;
    end else if ((k3 > ujcc_pkg::FW_LO) && (k3 < ujcc_pkg::FW_HI)) begin
      char_class = ujcc_pkg::CLASS_FULLWIDTH;
    end else if (k3 == ujcc_pkg::CP_COMMA) begin
      char_class = ujcc_pkg::CLASS_COMMA;
    end else if (k3 == ujcc_pkg::CP_STOP) begin
      char_class = ujcc_pkg::CLASS_STOP;
    end else if ((k3 == ujcc_pkg::CP_OPEN_A) || (k3 == ujcc_pkg::CP_OPEN_B)) begin
      char_class = ujcc_pkg::CLASS_OPEN;
    end else if ((k3 == ujcc_pkg::CP_CLOSE_A) || (k3 == ujcc_pkg::CP_CLOSE_B)) begin
      char_class = ujcc_pkg::CLASS_CLOSE;
    end else if (k3 == ujcc_pkg::CP_DOT) begin
      char_class = ujcc_pkg::CLASS_DOT;
    end else if (k3 == ujcc_pkg::CP_ITERATION) begin
      char_class = ujcc_pkg::CLASS_ITERATION;
    end else if (is_dash) begin
      char_class = ujcc_pkg::CLASS_DASH;
    end else begin
      char_class = ujcc_pkg::CLASS_OTHER;
    end
  end

  // fullwidth to ascii offsets
  assign fw_a = b2 - ujcc_pkg::FW_A_OFS;
  assign fw_b = b2 - ujcc_pkg::FW_B_OFS;

  // ascii equivalent
  always_comb begin
    priority if (b0 < ujcc_pkg::LEAD_TWO) begin
      ascii_equivalent = b0[ujcc_pkg::AsciiW-1:0];
    end else if ((b0 == ujcc_pkg::FW_LEAD) && (b2 >= ujcc_pkg::FW_CONT_MIN) &&
                 (b1 == ujcc_pkg::FW_ROW_A) && (b2 < ujcc_pkg::FW_A_END)) begin
      ascii_equivalent = fw_a[ujcc_pkg::AsciiW-1:0];
    end else if ((b0 == ujcc_pkg::FW_LEAD) && (b2 >= ujcc_pkg::FW_CONT_MIN) &&
                 (b1 == ujcc_pkg::FW_ROW_B) && (b2 < ujcc_pkg::FW_B_END)) begin
      ascii_equivalent = fw_b[ujcc_pkg::AsciiW-1:0];
    end else begin
      ascii_equivalent = '0;
    end
  end

endmodule

>>> src/utf8_japanese_char_classifier.sv
// top level of the japanese utf-8 character classifier
//
// Usage:
//   The input channel takes one character a transfer: in_utf8_bytes holds up
//   to four utf-8 bytes, first byte in bits 31:24, and a transfer happens at
//   each rising edge with start high and busy low. busy is always low, so a
//   new character may be offered in every cycle.
//   Each character yields exactly one result: out_char_class, out_byte_length
//   and out_ascii_equivalent, shown for one cycle while out_valid is high.
//   The result strobe follows the start cycle through the input register, then
//   the decode and the result register.
//   Throughput: one character per cycle; the only work is one pass of fixed
//   byte compares between the input register and the result register.
//   Reset (rst_n low, synchronous) drops any character in flight and clears
//   out_valid. The receiver cannot stall: every result is taken in the cycle
//   it is shown, so no result is ever held or lost.
module utf8_japanese_char_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ujcc_pkg::WordW-1:0]    in_utf8_bytes,
  output logic                          out_valid,
  output logic [ujcc_pkg::ClassW-1:0]   out_char_class,
  output logic [ujcc_pkg::LenW-1:0]     out_byte_length,
  output logic [ujcc_pkg::AsciiW-1:0]   out_ascii_equivalent
);

  logic                          in_valid_r;
  logic [ujcc_pkg::WordW-1:0]    in_word_r;
  ujcc_pkg::char_class_t         class_nxt;
  logic [ujcc_pkg::LenW-1:0]     len_nxt;
  logic [ujcc_pkg::AsciiW-1:0]   ascii_nxt;
  logic                          out_valid_r;
  ujcc_pkg::char_class_t         out_class_r;
  logic [ujcc_pkg::LenW-1:0]     out_len_r;
  logic [ujcc_pkg::AsciiW-1:0]   out_ascii_r;
  logic                          accept;

  // always ready for the next transfer
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word_r <= in_utf8_bytes;
    end
  end

  // decode
  ujcc_classify u_classify (
    .word             (in_word_r),
    .char_class       (class_nxt),
    .byte_length      (len_nxt),
    .ascii_equivalent (ascii_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_class_r <= class_nxt;
      out_len_r   <= len_nxt;
      out_ascii_r <= ascii_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_char_class       = out_class_r;
  assign out_byte_length      = out_len_r;
  assign out_ascii_equivalent = out_ascii_r;

  // every result follows a transfer through the input and result registers
  a_result_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept, 2))
    else $error("result without a matching transfer");

  // every held character reaches the result register next cycle
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_valid_r)
    else $error("character dropped between stages");

  // ascii class only for one-byte characters
  a_ascii_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_class_r == ujcc_pkg::CLASS_ASCII)) |->
      (out_len_r == ujcc_pkg::LEN_ONE))
    else $error("ascii class with wrong length");

  // four-byte kanji only for four-byte characters
  a_kanji4_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_class_r == ujcc_pkg::CLASS_KANJI4)) |->
      (out_len_r == ujcc_pkg::LEN_FOUR))
    else $error("four-byte kanji with wrong length");

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the japanese utf-8 character classifier
module tb_top;

  // one classified character
  typedef struct packed {
    ujcc_pkg::char_class_t       cls;
    logic [ujcc_pkg::LenW-1:0]   len;
    logic [ujcc_pkg::AsciiW-1:0] ascii;
  } char_result_t;

  // a character in flight and what it should come back as
  typedef struct {
    logic [ujcc_pkg::WordW-1:0] word;
    char_result_t               res;
  } pending_char_t;

  // one row of the directed table
  typedef struct {
    logic [ujcc_pkg::WordW-1:0] word;
    bit                         typed;
    char_result_t               res;
  } stim_row_t;

  localparam int unsigned DirectedN   = 25;
  localparam int unsigned RandomN     = 1225;
  localparam int unsigned QuietLimit  = 1000;
  localparam char_result_t NO_RESULT  = '{ujcc_pkg::CLASS_OTHER, 3'd0, 7'd0};

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [ujcc_pkg::WordW-1:0]    in_utf8_bytes = '0;
  logic                          out_valid;
  logic [ujcc_pkg::ClassW-1:0]   out_char_class;
  logic [ujcc_pkg::LenW-1:0]     out_byte_length;
  logic [ujcc_pkg::AsciiW-1:0]   out_ascii_equivalent;

  // typed expectation that rides along with the offered character
  bit                 row_typed = 1'b0;
  char_result_t       row_result = NO_RESULT;

  pending_char_t      pending_chars[$];
  int unsigned        error_count = 0;
  int unsigned        quiet_cycles = 0;
  stim_row_t          directed_rows [DirectedN];

  utf8_japanese_char_classifier u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_utf8_bytes        (in_utf8_bytes),
    .out_valid            (out_valid),
    .out_char_class       (out_char_class),
    .out_byte_length      (out_byte_length),
    .out_ascii_equivalent (out_ascii_equivalent)
  );

  always #1 clk = ~clk;

  // open interval test on leading bytes or a whole word
  function automatic bit strictly_between(input logic [31:0] v, input logic [31:0] lo,
                                          input logic [31:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  // expected class, length and ascii form of one character
  function automatic char_result_t classify_char(input logic [ujcc_pkg::WordW-1:0] w);
    char_result_t r;
    logic [7:0]   b0;
    logic [7:0]   b1;
    logic [7:0]   b2;
    logic [7:0]   shifted;
    logic [23:0]  lead3;
    bit           is_dash;
    b0 = w[31:24];
    b1 = w[23:16];
    b2 = w[15:8];
    lead3 = w[31:8];
    is_dash = 1'b0;
    for (int i = 0; i < ujcc_pkg::DashN; i++) begin
      if (lead3 == ujcc_pkg::DASH_POINTS[i]) is_dash = 1'b1;
    end

    // length from lead byte only
    if (b0 < ujcc_pkg::LEAD_TWO) r.len = ujcc_pkg::LEN_ONE;
    else if (b0 < ujcc_pkg::LEAD_THREE) r.len = ujcc_pkg::LEN_TWO;
    else if (b0 < ujcc_pkg::LEAD_FOUR) r.len = ujcc_pkg::LEN_THREE;
    else r.len = ujcc_pkg::LEN_FOUR;

    // class, first match wins
    if (r.len == ujcc_pkg::LEN_ONE)
      r.cls = ujcc_pkg::CLASS_ASCII;
    else if (r.len == ujcc_pkg::LEN_TWO || lead3 == ujcc_pkg::CP_IDEO_SPACE)
      r.cls = ujcc_pkg::CLASS_OTHER;
    else if (b0 > ujcc_pkg::K3_LEAD_GT &&
             (strictly_between(lead3, ujcc_pkg::K3A_LO, ujcc_pkg::K3A_HI) ||
              strictly_between(lead3, ujcc_pkg::K3B_LO, ujcc_pkg::K3B_HI)))
      r.cls = ujcc_pkg::CLASS_KANJI3;
    else if (b0 == ujcc_pkg::LEAD_FOUR &&
             strictly_between(w, ujcc_pkg::K4_LO, ujcc_pkg::K4_HI))
      r.cls = ujcc_pkg::CLASS_KANJI4;
    else if (strictly_between(lead3, ujcc_pkg::KATA_LO, ujcc_pkg::KATA_HI))
      r.cls = ujcc_pkg::CLASS_KATAKANA;
    else if (strictly_between(lead3, ujcc_pkg::HIRA_LO, ujcc_pkg::HIRA_HI))
      r.cls = ujcc_pkg::CLASS_HIRAGANA;
    else if (strictly_between(lead3, ujcc_pkg::FW_LO, ujcc_pkg::FW_HI))
      r.cls = ujcc_pkg::CLASS_FULLWIDTH;
    else if (lead3 == ujcc_pkg::CP_COMMA)
      r.cls = ujcc_pkg::CLASS_COMMA;
    else if (lead3 == ujcc_pkg::CP_STOP)
      r.cls = ujcc_pkg::CLASS_STOP;
    else if (lead3 == ujcc_pkg::CP_OPEN_A || lead3 == ujcc_pkg::CP_OPEN_B)
      r.cls = ujcc_pkg::CLASS_OPEN;
    else if (lead3 == ujcc_pkg::CP_CLOSE_A || lead3 == ujcc_pkg::CP_CLOSE_B)
      r.cls = ujcc_pkg::CLASS_CLOSE;
    else if (lead3 == ujcc_pkg::CP_DOT)
      r.cls = ujcc_pkg::CLASS_DOT;
    else if (lead3 == ujcc_pkg::CP_ITERATION)
      r.cls = ujcc_pkg::CLASS_ITERATION;
    else if (is_dash)
      r.cls = ujcc_pkg::CLASS_DASH;
    else
      r.cls = ujcc_pkg::CLASS_OTHER;

    // ascii form, fullwidth rows folded back
    r.ascii = '0;
    if (b0 < ujcc_pkg::LEAD_TWO) begin
      r.ascii = b0[6:0];
    end else if (b0 == ujcc_pkg::FW_LEAD && b2 >= ujcc_pkg::FW_CONT_MIN) begin
      if (b1 == ujcc_pkg::FW_ROW_A && b2 < ujcc_pkg::FW_A_END) begin
        shifted = b2 - ujcc_pkg::FW_A_OFS;
        r.ascii = shifted[6:0];
      end else if (b1 == ujcc_pkg::FW_ROW_B && b2 < ujcc_pkg::FW_B_END) begin
        shifted = b2 - ujcc_pkg::FW_B_OFS;
        r.ascii = shifted[6:0];
      end
    end
    return r;
  endfunction

  // random character, mostly near the interesting code points
  function automatic logic [ujcc_pkg::WordW-1:0] pick_char();
    logic [23:0] bounds [16];
    logic [23:0] base;
    bounds = '{ujcc_pkg::K3A_LO, ujcc_pkg::K3A_HI, ujcc_pkg::K3B_LO, ujcc_pkg::K3B_HI,
               ujcc_pkg::KATA_LO, ujcc_pkg::KATA_HI, ujcc_pkg::HIRA_LO, ujcc_pkg::HIRA_HI,
               ujcc_pkg::FW_LO, ujcc_pkg::FW_HI, ujcc_pkg::CP_IDEO_SPACE,
               ujcc_pkg::CP_OPEN_A, ujcc_pkg::CP_CLOSE_B, ujcc_pkg::CP_DOT,
               ujcc_pkg::CP_ITERATION,
               ujcc_pkg::DASH_POINTS[$urandom_range(0, ujcc_pkg::DashN - 1)]};
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: return {1'b0, 31'($urandom())};
      3: return {8'hE3, 8'($urandom_range(8'h80, 8'h83)), 8'($urandom_range(8'h80, 8'hBF)),
                 8'($urandom())};
      4: return {ujcc_pkg::FW_LEAD,
                 ($urandom_range(0, 1) != 0) ? ujcc_pkg::FW_ROW_A : ujcc_pkg::FW_ROW_B,
                 8'($urandom()), 8'($urandom())};
      5: return {ujcc_pkg::LEAD_FOUR, 8'($urandom_range(8'h9E, 8'hB2)), 16'($urandom())};
      6: begin
        base = bounds[$urandom_range(0, 15)] + 24'($urandom_range(0, 2)) - 24'd1;
        return {base, 8'($urandom())};
      end
      7: return {8'($urandom_range(8'hE0, 8'hEF)), 8'($urandom_range(8'h80, 8'hBF)),
                 8'($urandom_range(8'h80, 8'hBF)), 8'($urandom())};
      8: return {8'hE2, ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h88,
                 8'($urandom_range(8'h8E, 8'h97)), 8'($urandom())};
      default: return {8'($urandom_range(8'hE3, 8'hE9)), 16'($urandom()), 8'($urandom())};
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [ujcc_pkg::WordW-1:0] word,
                                 input int got, input int want);
    $display("mismatch on %s for %h: got %0d, expected %0d", field, word, got, want);
    error_count++;
  endtask

  // offer one character, idling first at random; returns at the falling edge after transfer
  task automatic send_char(input logic [ujcc_pkg::WordW-1:0] word, input bit typed,
                           input char_result_t res, input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_utf8_bytes <= $urandom();
      @(negedge clk);
    end
    start <= 1'b1;
    in_utf8_bytes <= word;
    row_typed <= typed;
    row_result <= res;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // stop offering until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  // track transfers, check results, watch for a stall
  always @(posedge clk) begin : monitor
    pending_char_t head;
    bit            moved;
    if (rst_n) begin
      moved = 1'b0;
      if (start && !busy) begin
        pending_chars.push_back('{in_utf8_bytes,
                                  row_typed ? row_result : classify_char(in_utf8_bytes)});
        moved = 1'b1;
      end
      if (out_valid) begin
        moved = 1'b1;
        if (pending_chars.size() == 0) begin
          report_mismatch("unexpected result", '0, out_char_class, -1);
        end else begin
          head = pending_chars.pop_front();
          if (out_char_class !== head.res.cls)
            report_mismatch("char_class", head.word, out_char_class, head.res.cls);
          if (out_byte_length !== head.res.len)
            report_mismatch("byte_length", head.word, out_byte_length, head.res.len);
          if (out_ascii_equivalent !== head.res.ascii)
            report_mismatch("ascii_equivalent", head.word, out_ascii_equivalent,
                            head.res.ascii);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no transfer for %0d cycles", QuietLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned idle_pct [3];
    idle_pct = '{30, 55, 0};

    // extremes, every class and the malformed corners
    directed_rows = '{
      '{32'h00000000, 1'b1, '{ujcc_pkg::CLASS_ASCII, ujcc_pkg::LEN_ONE, 7'h00}},
      '{32'h7FFFFFFF, 1'b1, '{ujcc_pkg::CLASS_ASCII, ujcc_pkg::LEN_ONE, 7'h7F}},
      '{32'h80000000, 1'b1, '{ujcc_pkg::CLASS_OTHER, ujcc_pkg::LEN_TWO, 7'h00}},
      '{32'hDFFFFFFF, 1'b1, '{ujcc_pkg::CLASS_OTHER, ujcc_pkg::LEN_TWO, 7'h00}},
      '{32'hE3808000, 1'b1, '{ujcc_pkg::CLASS_OTHER, ujcc_pkg::LEN_THREE, 7'h00}},
      '{32'hFFFFFFFF, 1'b1, '{ujcc_pkg::CLASS_OTHER, ujcc_pkg::LEN_FOUR, 7'h00}},
      '{32'hE38FC000, 1'b0, NO_RESULT},
      '{32'hE9BFAEFF, 1'b0, NO_RESULT},
      '{32'hEFA48000, 1'b0, NO_RESULT},
      '{32'hF0A08080, 1'b0, NO_RESULT},
      '{32'hF09FAFBF, 1'b0, NO_RESULT},
      '{32'hE382A155, 1'b0, NO_RESULT},
      '{32'hE3818100, 1'b0, NO_RESULT},
      '{32'hEFBC81AA, 1'b0, NO_RESULT},
      '{32'hEFBD9E00, 1'b0, NO_RESULT},
      '{32'hE3808100, 1'b0, NO_RESULT},
      '{32'hE3808200, 1'b0, NO_RESULT},
      '{32'hE3808C00, 1'b0, NO_RESULT},
      '{32'hE3808F00, 1'b0, NO_RESULT},
      '{32'hE383BB00, 1'b0, NO_RESULT},
      '{32'hE380BB00, 1'b0, NO_RESULT},
      '{32'hE2809400, 1'b0, NO_RESULT},
      '{32'hE2889200, 1'b0, NO_RESULT},
      '{32'hEFBC4100, 1'b0, NO_RESULT},
      '{32'hEFBCC000, 1'b0, NO_RESULT}
    };

    // hold synchronous reset, then release it at a falling edge
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res,
                idle_pct[0]);
    end
    drain_results();

    // random phases with different sender gaps, full drain between them
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < RandomN / 3; n++) begin
        send_char(pick_char(), 1'b0, NO_RESULT, idle_pct[phase]);
      end
      drain_results();
    end

    // let any stray strobe show up
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
